FILE: rtl/core/bmp24_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// bmp24 stream decoder assertion macros
// concurrent check wrappers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_DECODER_CORE_ASSERT_SVH
`define BMP24_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BMP24_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMP24_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMP24_ASSERT(name, clk, rst_n, prop, msg)
`define BMP24_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

FILE: rtl/core/bmp24_pkg.sv
// ----------------------------------------------------------------------------
// bmp24_pkg
// transaction types and header layout constants for the 24-bit bmp decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmp24_pkg;

    localparam int COORD_W = 12;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } bmp24_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        coord_t     column;
        coord_t     row;
        logic       last_pixel;
        logic       rejected;
    } bmp24_out_t;

    // header layout
    localparam logic [5:0]  HDR_LAST_IDX = 6'd53;
    localparam logic [5:0]  WIDTH_OFS    = 6'h12;
    localparam logic [5:0]  HEIGHT_OFS   = 6'h16;
    localparam logic [5:0]  BPP_OFS      = 6'h1C;
    localparam logic [15:0] BPP_RGB24    = 16'd24;

endpackage

`default_nettype wire

FILE: rtl/core/bmp24_skid.sv
// ----------------------------------------------------------------------------
// bmp24_skid
// two-entry output register slice with registered upstream ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bmp24_stream_decoder_core_assert.svh"

module bmp24_skid (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bmp24_pkg::bmp24_out_t in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bmp24_pkg::bmp24_out_t      out_data
);

    logic                  main_valid_reg, main_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    bmp24_pkg::bmp24_out_t main_reg, main_next;
    bmp24_pkg::bmp24_out_t skid_reg, skid_next;
    logic                  pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pop || !main_valid_reg) begin
            main_valid_next = in_valid;
            main_next       = in_data;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `BMP24_ASSERT(a_skid_needs_main, aclk, aresetn, skid_valid_reg |-> main_valid_reg, "skid entry without main entry")
    `BMP24_ASSERT(a_no_push_when_full, aclk, aresetn, in_valid |-> in_ready, "push into full slice")
    `BMP24_ASSERT(a_skid_drains_first, aclk, aresetn, (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg), "skid entry not moved to main")

endmodule

`default_nettype wire

FILE: rtl/core/bmp24_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_core
// streaming 24-bit bmp decoder: header parse, pixel assembly, row padding skip
// ----------------------------------------------------------------------------
// Takes one file byte per clock cycle while s_ready is high, with no gaps
// between files or pixels. Each byte is decoded by the header/pixel logic in
// the cycle it is accepted; a header rejection or a completed blue-green-red
// pixel lands in a two-entry output slice the next cycle. s_ready is
// registered and drops only when both slice entries hold results that
// m_ready has not taken. Column and row are the low 12 bits of counters
// sized by MAX_DIM.
`timescale 1ns / 1ps
`default_nettype none

`include "bmp24_stream_decoder_core_assert.svh"

module bmp24_stream_decoder_core #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bmp24_pkg::bmp24_in_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bmp24_pkg::bmp24_out_t      m_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_IDLE
    } phase_t;

    phase_t             phase_reg, phase_next, phase_cur;
    logic [5:0]         hidx_reg, hidx_next, hidx_cur;
    logic [31:0]        width_reg, width_next;
    logic [31:0]        height_reg, height_next;
    logic [15:0]        bpp_reg, bpp_next;
    logic [DIM_W-1:0]   col_reg, col_next, col_inc;
    logic [DIM_W-1:0]   row_reg, row_next, row_inc;
    logic [1:0]         bip_reg, bip_next;
    logic [1:0]         pad_reg, pad_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;

    logic                  accept;
    logic                  push;
    logic                  row_end;
    logic                  last;
    logic                  hdr_bad;
    bmp24_pkg::bmp24_out_t res;

    assign accept  = s_valid && s_ready;
    assign col_inc = col_reg + 1'b1;
    assign row_inc = row_reg + 1'b1;
    assign row_end = (col_inc == width_reg[DIM_W-1:0]);
    assign last    = row_end && (row_inc == height_reg[DIM_W-1:0]);

    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        width_next = width_reg;
        height_next = height_reg;
        bpp_next   = bpp_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        bip_next   = bip_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        push       = 1'b0;
        res        = '0;
        hdr_bad    = 1'b0;
        phase_cur  = s_data.start_of_file ? PH_HEADER : phase_reg;
        hidx_cur   = s_data.start_of_file ? 6'd0 : hidx_reg;

        if (accept) begin
            unique case (phase_cur)
                PH_HEADER: begin
                    for (int k = 0; k < 4; k++) begin
                        if (hidx_cur == bmp24_pkg::WIDTH_OFS + 6'(k)) begin
                            width_next[8*k +: 8] = s_data.data_byte;
                        end
                        if (hidx_cur == bmp24_pkg::HEIGHT_OFS + 6'(k)) begin
                            height_next[8*k +: 8] = s_data.data_byte;
                        end
                    end
                    for (int k = 0; k < 2; k++) begin
                        if (hidx_cur == bmp24_pkg::BPP_OFS + 6'(k)) begin
                            bpp_next[8*k +: 8] = s_data.data_byte;
                        end
                    end
                    phase_next = PH_HEADER;
                    if (hidx_cur == bmp24_pkg::HDR_LAST_IDX) begin
                        hidx_next = 6'd0;
                        hdr_bad = (bpp_next != bmp24_pkg::BPP_RGB24)
                               || (width_next == 32'd0) || (height_next == 32'd0)
                               || (width_next > 32'(MAX_DIM))
                               || (height_next > 32'(MAX_DIM));
                        if (hdr_bad) begin
                            phase_next   = PH_IDLE;
                            push         = 1'b1;
                            res.rejected = 1'b1;
                        end else begin
                            phase_next = PH_PIXEL;
                            col_next   = '0;
                            row_next   = '0;
                            bip_next   = 2'd0;
                            pad_next   = 2'd0;
                        end
                    end else begin
                        hidx_next = hidx_cur + 6'd1;
                    end
                end
                PH_PIXEL: begin
                    priority if (pad_reg != 2'd0) begin
                        pad_next = pad_reg - 2'd1;
                    end else if (bip_reg == 2'd0) begin
                        blue_next = s_data.data_byte;
                        bip_next  = 2'd1;
                    end else if (bip_reg == 2'd1) begin
                        green_next = s_data.data_byte;
                        bip_next   = 2'd2;
                    end else begin
                        bip_next       = 2'd0;
                        push           = 1'b1;
                        res.red        = s_data.data_byte;
                        res.green      = green_reg;
                        res.blue       = blue_reg;
                        res.column     = bmp24_pkg::coord_t'(col_reg);
                        res.row        = bmp24_pkg::coord_t'(row_reg);
                        res.last_pixel = last;
                        if (last) begin
                            phase_next = PH_IDLE;
                        end else if (row_end) begin
                            col_next = '0;
                            row_next = row_inc;
                            pad_next = width_reg[1:0];
                        end else begin
                            col_next = col_inc;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            bpp_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

    bmp24_skid u_out_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    `BMP24_ASSERT(a_hidx_outside_header, aclk, aresetn, (phase_reg != PH_HEADER) |-> (hidx_reg == 6'd0), "header index left nonzero")
    `BMP24_ASSERT(a_pad_between_pixels, aclk, aresetn, (pad_reg != 2'd0) |-> (bip_reg == 2'd0), "padding inside a pixel")
    `BMP24_ASSERT(a_col_in_range, aclk, aresetn, (phase_reg == PH_PIXEL) |-> (col_reg < width_reg[DIM_W-1:0]), "column beyond width")
    `BMP24_ASSERT(a_push_only_on_accept, aclk, aresetn, push |-> accept, "result without transaction")

endmodule

`default_nettype wire

FILE: tb/sv/bmp24_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_decoder_checker
// follows every accepted file byte through its own header and pixel decoder,
// queues the pixels and rejections it predicts, and compares each result
// transaction against them field by field
// ----------------------------------------------------------------------------

module bmp24_decoder_checker
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  bmp24_in_t  s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  bmp24_out_t m_data,
    input  logic       test_done,
    output int         mismatch_count,
    output int         pending_results
);

    typedef enum logic [1:0] {PH_HEADER, PH_PIXEL, PH_IDLE} phase_t;

    phase_t      phase;
    logic [5:0]  hdr_idx;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] bpp;
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [1:0]  byte_pos;
    logic [1:0]  pad_left;
    logic [7:0]  blue_l;
    logic [7:0]  green_l;

    bmp24_out_t decoded_q[$];
    bmp24_out_t px;
    bmp24_out_t want;
    bit         leftovers_checked = 1'b0;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    function automatic bit decode_byte(input bmp24_in_t in, output bmp24_out_t res);
        logic [5:0] idx;
        bit         last;
        res = '0;
        if (in.start_of_file) begin
            phase   = PH_HEADER;
            hdr_idx = '0;
        end
        if (phase == PH_HEADER) begin
            idx = hdr_idx;
            if (idx >= WIDTH_OFS && idx <= WIDTH_OFS + 3) begin
                img_w[8*(idx-WIDTH_OFS) +: 8] = in.data_byte;
            end else if (idx >= HEIGHT_OFS && idx <= HEIGHT_OFS + 3) begin
                img_h[8*(idx-HEIGHT_OFS) +: 8] = in.data_byte;
            end else if (idx >= BPP_OFS && idx <= BPP_OFS + 1) begin
                bpp[8*(idx-BPP_OFS) +: 8] = in.data_byte;
            end
            if (idx != HDR_LAST_IDX) begin
                hdr_idx = idx + 6'd1;
                return 1'b0;
            end
            hdr_idx = '0;
            if (bpp != BPP_RGB24 || img_w == 0 || img_h == 0 ||
                img_w > MAX_DIM || img_h > MAX_DIM) begin
                phase        = PH_IDLE;
                res.rejected = 1'b1;
                return 1'b1;
            end
            phase    = PH_PIXEL;
            col_cnt  = 0;
            row_cnt  = 0;
            byte_pos = '0;
            pad_left = '0;
            return 1'b0;
        end
        if (phase != PH_PIXEL) begin
            return 1'b0;
        end
        if (pad_left != 0) begin
            pad_left = pad_left - 2'd1;
            return 1'b0;
        end
        if (byte_pos == 2'd0) begin
            blue_l   = in.data_byte;
            byte_pos = 2'd1;
            return 1'b0;
        end
        if (byte_pos == 2'd1) begin
            green_l  = in.data_byte;
            byte_pos = 2'd2;
            return 1'b0;
        end
        byte_pos       = 2'd0;
        last           = (col_cnt + 1 == img_w) && (row_cnt + 1 == img_h);
        res.red        = in.data_byte;
        res.green      = green_l;
        res.blue       = blue_l;
        res.column     = col_cnt[COORD_W-1:0];
        res.row        = row_cnt[COORD_W-1:0];
        res.last_pixel = last;
        if (last) begin
            phase = PH_IDLE;
        end else if (col_cnt + 1 == img_w) begin
            col_cnt  = 0;
            row_cnt  = row_cnt + 1;
            pad_left = img_w[1:0];
        end else begin
            col_cnt = col_cnt + 1;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_result(input bmp24_out_t got, input bmp24_out_t exp_px);
        if (got.red !== exp_px.red)
            report_mismatch($sformatf("red %h, want %h", got.red, exp_px.red));
        if (got.green !== exp_px.green)
            report_mismatch($sformatf("green %h, want %h", got.green, exp_px.green));
        if (got.blue !== exp_px.blue)
            report_mismatch($sformatf("blue %h, want %h", got.blue, exp_px.blue));
        if (got.column !== exp_px.column)
            report_mismatch($sformatf("column %0d, want %0d", got.column, exp_px.column));
        if (got.row !== exp_px.row)
            report_mismatch($sformatf("row %0d, want %0d", got.row, exp_px.row));
        if (got.last_pixel !== exp_px.last_pixel)
            report_mismatch($sformatf("last_pixel %b, want %b",
                                      got.last_pixel, exp_px.last_pixel));
        if (got.rejected !== exp_px.rejected)
            report_mismatch($sformatf("rejected %b, want %b", got.rejected, exp_px.rejected));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase    = PH_HEADER;
            hdr_idx  = '0;
            img_w    = '0;
            img_h    = '0;
            bpp      = '0;
            col_cnt  = 0;
            row_cnt  = 0;
            byte_pos = '0;
            pad_left = '0;
            blue_l   = '0;
            green_l  = '0;
            decoded_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (decode_byte(s_data, px)) decoded_q.push_back(px);
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction %h", m_data));
                end else begin
                    want = decoded_q.pop_front();
                    compare_result(m_data, want);
                end
            end
            if (test_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (decoded_q.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
            end
        end
        pending_results = decoded_q.size();
    end

endmodule

FILE: tb/sv/tb_bmp24_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp24_stream_decoder_core
// streams bmp files through the decoder: directed headers, padding widths,
// rejections, restarts and largest dimensions, then random files and noise,
// with bursty input, a stalling receiver and one long back-pressure hold
// ----------------------------------------------------------------------------

module tb_bmp24_stream_decoder_core;
    import bmp24_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 500;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;
    typedef enum {FILE_GOOD, FILE_BAD_HEADER, FILE_NOISE, FILE_CUT_HEADER} file_kind_t;
    typedef enum {BAD_BPP, BAD_ZERO_W, BAD_ZERO_H, BAD_BIG_W, BAD_BIG_H} bad_kind_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    bmp24_in_t  s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    bmp24_out_t m_data;
    logic       test_done = 1'b0;
    int         mismatches;
    int         results_pending;

    int         burst_left    = 0;
    int         gap_max       = 3;
    rx_mode_t   rx_mode       = RX_PATTERN;
    int         hold_requests = 0;
    int         hold_served   = 0;
    int         stall_cycles  = 0;

    always #CLK_HALF aclk = ~aclk;

    bmp24_stream_decoder_core #(
        .MAX_DIM (MAX_DIM)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bmp24_decoder_checker #(
        .MAX_DIM (MAX_DIM)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .test_done       (test_done),
        .mismatch_count  (mismatches),
        .pending_results (results_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver stall pattern, with long holds on request
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_served != hold_requests) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_served++;
            end
            case (rx_mode)
                RX_ALWAYS:  m_ready = 1'b1;
                RX_RANDOM:  m_ready = 1'($urandom_range(0, 1));
                RX_PATTERN: m_ready = (cyc % 5 != 0) && (cyc % 7 != 3);
                default:    m_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic int image_bytes(input int w, input int h);
        return h * (3 * w + w % 4);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic sof);
        int gap;
        s_data.data_byte     = b;
        s_data.start_of_file = sof;
        s_valid              = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic push_random(input int n, input int sof_odds);
        int i;
        for (i = 0; i < n; i++)
            push_byte(8'($urandom), sof_odds != 0 && $urandom_range(1, sof_odds) == 1);
    endtask

    task automatic push_header(input logic [31:0] w, input logic [31:0] h,
                               input logic [15:0] bits, input logic sof, input int len = 54);
        int         i;
        logic [7:0] b;
        for (i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i >= WIDTH_OFS && i < WIDTH_OFS + 4)
                b = w[8*(i-WIDTH_OFS) +: 8];
            else if (i >= HEIGHT_OFS && i < HEIGHT_OFS + 4)
                b = h[8*(i-HEIGHT_OFS) +: 8];
            else if (i >= BPP_OFS && i < BPP_OFS + 2)
                b = bits[8*(i-BPP_OFS) +: 8];
            push_byte(b, i == 0 ? sof : 1'b0);
        end
    endtask

    task automatic push_file(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bits, input int body);
        push_header(w, h, bits, 1'b1);
        push_random(body, 0);
    endtask

    task automatic wait_drained;
        s_valid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int          n;
        int          useful;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bits;
        file_kind_t  kind;
        int          r;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // first header right after reset carries no start flag
        push_header(2, 2, BPP_RGB24, 1'b0);
        push_random(image_bytes(2, 2) + 3, 0);
        // all-ones and all-zeros pixels
        push_header(1, 1, BPP_RGB24, 1'b1);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_header(1, 1, BPP_RGB24, 1'b1);
        repeat (4) push_byte(8'h00, 1'b0);
        // every row padding length, with trailing bytes after the last pixel
        for (n = 3; n <= 6; n++) push_file(n, 2, BPP_RGB24, image_bytes(n, 2) + 2);
        // unsupported headers
        push_file(2, 2, 16'd32, 5);
        push_file(2, 2, 16'h0118, 5);
        push_file(0, 3, BPP_RGB24, 5);
        push_file(3, 0, BPP_RGB24, 5);
        push_file(MAX_DIM + 1, 1, BPP_RGB24, 5);
        push_file(1, MAX_DIM + 1, BPP_RGB24, 5);
        push_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5);
        // restart inside a header and inside pixel data
        push_header(7, 7, BPP_RGB24, 1'b1, 30);
        push_file(2, 3, BPP_RGB24, 7);
        push_file(3, 1, BPP_RGB24, image_bytes(3, 1));
        wait_drained;

        // receiver holds off while the sender keeps streaming
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        hold_requests++;
        push_file(8, 8, BPP_RGB24, image_bytes(8, 8));
        wait_drained;

        // largest accepted dimensions, first pixels only
        gap_max = 2;
        rx_mode = RX_RANDOM;
        push_file(MAX_DIM, 1, BPP_RGB24, 30);
        push_file(1, MAX_DIM, BPP_RGB24, 40);
        wait_drained;

        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            gap_max = $urandom_range(0, 2) * 4;
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            r = $urandom_range(0, 9);
            kind = r < 7 ? FILE_GOOD : r == 7 ? FILE_BAD_HEADER :
                   r == 8 ? FILE_NOISE : FILE_CUT_HEADER;
            case (kind)
                FILE_GOOD: begin
                    w = $urandom_range(1, 9);
                    h = $urandom_range(1, 5);
                    n = image_bytes(w, h);
                    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
                    else n += $urandom_range(0, 4);
                    push_file(w, h, BPP_RGB24, n);
                    useful += 54 + n;
                end
                FILE_BAD_HEADER: begin
                    w    = $urandom_range(1, 9);
                    h    = $urandom_range(1, 5);
                    bits = BPP_RGB24;
                    case (bad_kind_t'($urandom_range(0, 4)))
                        BAD_BPP: begin
                            bits = 16'($urandom);
                            if (bits == BPP_RGB24) bits = ~bits;
                        end
                        BAD_ZERO_W: w = 0;
                        BAD_ZERO_H: h = 0;
                        BAD_BIG_W: begin
                            w = $urandom;
                            if (w <= MAX_DIM) w = MAX_DIM + 1;
                        end
                        default: begin
                            h = $urandom;
                            if (h <= MAX_DIM) h = MAX_DIM + 1;
                        end
                    endcase
                    push_file(w, h, bits, $urandom_range(0, 8));
                end
                FILE_NOISE: push_random($urandom_range(1, 40), 16);
                default: push_header($urandom_range(1, 9), $urandom_range(1, 5),
                                     BPP_RGB24, 1'b1, $urandom_range(1, 53));
            endcase
            if ($urandom_range(0, 7) == 0) wait_drained;
        end

        wait_drained;
        test_done = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
